// ===== design/gb3_pkg.sv =====
// Shared types, constants and the binomial kernel for the 3x3 RGB blur.
package gb3_pkg;

    localparam int MAX_W   = 2048;
    localparam int ADDR_W  = $clog2(MAX_W);
    localparam int COL_W   = 11;
    localparam int ROW_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 2;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [CFG_A_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic [11:0]      WIDTH_RST  = 12'd640;
    localparam logic [ROW_W-1:0] HEIGHT_RST = 16'd480;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix;

    // Window columns c-2 (0..2) and c-1 (3..5), top to bottom, plus column c.
    typedef struct packed {
        t_pix [5:0]       win;
        t_pix             top;
        t_pix             mid;
        t_pix             bot;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             blur_en;
        logic             pass_en;
        logic             done;
    } t_job;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        t_pix             pix;
        logic             last;
        logic             done;
    } t_res;

    function automatic logic [7:0] blur_chan(
        input logic [7:0] a0, input logic [7:0] a1, input logic [7:0] a2,
        input logic [7:0] a3, input logic [7:0] a4, input logic [7:0] a5,
        input logic [7:0] t,  input logic [7:0] m,  input logic [7:0] b
    );
        logic [11:0] s;
        s = {4'd0, a0} + {4'd0, a2} + {4'd0, t} + {4'd0, b}
          + {3'd0, a1, 1'b0} + {3'd0, a3, 1'b0} + {3'd0, a5, 1'b0} + {3'd0, m, 1'b0}
          + {2'd0, a4, 2'b0};
        return s[11:4];
    endfunction

    function automatic t_pix blur_pix(input t_job j);
        t_pix p;
        p.red   = blur_chan(j.win[0].red, j.win[1].red, j.win[2].red,
                            j.win[3].red, j.win[4].red, j.win[5].red,
                            j.top.red, j.mid.red, j.bot.red);
        p.green = blur_chan(j.win[0].green, j.win[1].green, j.win[2].green,
                            j.win[3].green, j.win[4].green, j.win[5].green,
                            j.top.green, j.mid.green, j.bot.green);
        p.blue  = blur_chan(j.win[0].blue, j.win[1].blue, j.win[2].blue,
                            j.win[3].blue, j.win[4].blue, j.win[5].blue,
                            j.top.blue, j.mid.blue, j.bot.blue);
        return p;
    endfunction

endpackage

// ===== design/rgb_gaussian_blur_3x3.sv =====
// Top level of the streaming 3x3 binomial blur for RGB frames.
//
// Pixels enter on the s_axis channel in raster order, one request per pixel.
// Results leave on m_axis tagged with column and row. Border pixels pass
// through; each interior pixel is blurred and emitted when its lower-right
// neighbour arrives, ahead of that neighbour's pass-through if any. tlast marks
// the final result of a request, tuser the final result of the frame.
// Frame width and height are set through the write port; any such write
// restarts the frame at column 0, row 0.
// A request passes through the front-end register and the job queue into the
// result register. Intake is one pixel per cycle while the queue has room;
// a request with two results fills the result register with both in turn.
// The job queue absorbs isolated pairs, but along the last row every pixel
// from column 2 on gives two results, so intake there waits for each second one.
// The line stores are one 2048 x 48-bit RAM, read at request time and
// written back as the request enters the queue; one-pixel rows forward.
// Reset clears the counters, the window and the queue and loads 640 x 480.
// When the receiver stalls the result holds, the queue fills and then
// s_axis_tready drops.
module rgb_gaussian_blur_3x3
    import gb3_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,  // in_red, in_green, in_blue
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [55:0]        m_axis_tdata,  // out_col, out_row, out_red, out_green,
                                              // out_blue, zero fill
    output logic               m_axis_tlast,
    output logic               m_axis_tuser   // frame_done
);

    t_pix in_pix;
    t_job push_job, head_job;
    logic push, full, pop, empty;
    t_res res;

    assign in_pix.red   = s_axis_tdata[7:0];
    assign in_pix.green = s_axis_tdata[15:8];
    assign in_pix.blue  = s_axis_tdata[23:16];

    gb3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_pix       (in_pix),
        .o_push      (push),
        .o_job       (push_job),
        .i_full      (full)
    );

    gb3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    gb3_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {5'd0, res.pix.blue, res.pix.green, res.pix.red, res.row, res.col};
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.done;

endmodule

// ===== design/gb3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gb3_queue.sv =====
// Short job queue between the window front end and the result back end.
module gb3_queue
    import gb3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full  = (r_cnt == (QPTR_W + 1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

endmodule

// ===== design/gb3_front.sv =====
// Front end: request intake, raster counters, line stores and 3x3 window.
module gb3_front
    import gb3_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_pix               i_pix,
    output logic               o_push,
    output t_job               o_job,
    input  logic               i_full
);

    logic [11:0]      r_img_w;
    logic [ROW_W-1:0] r_img_h;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;
    logic             last_col, last_row, accept, cfg_hit;

    logic             r_s1_valid;
    t_pix             r_s1_pix;
    logic [COL_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_blur, r_s1_pass, r_s1_done;
    logic             r_s1_byp;
    logic [47:0]      r_s1_byp_data;
    t_pix [5:0]       r_win;

    logic [47:0]      ram_rdata, rows;
    t_pix             top, mid;

    always_comb begin
        if (r_img_w == 12'd0) begin
            wm1 = '0;
        end else if (r_img_w > 12'(MAX_W)) begin
            wm1 = COL_W'(MAX_W - 1);
        end else begin
            wm1 = COL_W'(r_img_w - 12'd1);
        end
        hm1 = (r_img_h == '0) ? '0 : r_img_h - 1'b1;
    end

    assign last_col = (r_col >= wm1);
    assign last_row = (r_row >= hm1);
    assign o_push   = r_s1_valid && !i_full;
    assign o_ready  = !r_s1_valid || o_push;
    assign accept   = i_valid && o_ready;
    assign cfg_hit  = i_cfg_we && (i_cfg_addr == CFG_WIDTH || i_cfg_addr == CFG_HEIGHT);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= WIDTH_RST;
            r_img_h <= HEIGHT_RST;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            if (i_cfg_we && i_cfg_addr == CFG_WIDTH) begin
                r_img_w <= i_cfg_wdata[11:0];
            end
            if (i_cfg_we && i_cfg_addr == CFG_HEIGHT) begin
                r_img_h <= i_cfg_wdata;
            end
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    gb3_ram #(
        .WIDTH (48),
        .DEPTH (MAX_W)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (o_push),
        .i_waddr (ADDR_W'(r_s1_col)),
        .i_wdata ({mid, r_s1_pix}),
        .i_re    (accept),
        .i_raddr (ADDR_W'(r_col)),
        .o_rdata (ram_rdata)
    );

    assign rows = r_s1_byp ? r_s1_byp_data : ram_rdata;
    assign top  = rows[47:24];
    assign mid  = rows[23:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_byp   <= 1'b0;
            r_win      <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1_byp   <= o_push && (r_s1_col == r_col);
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
            if (o_push) begin
                r_win <= {r_s1_pix, mid, top, r_win[5], r_win[4], r_win[3]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= i_pix;
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_blur     <= (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
            r_s1_pass     <= (r_row == '0) || last_row || (r_col == '0) || last_col;
            r_s1_done     <= last_col && last_row;
            r_s1_byp_data <= {mid, r_s1_pix};
        end
    end

    always_comb begin
        o_job         = '0;
        o_job.win     = r_win;
        o_job.top     = top;
        o_job.mid     = mid;
        o_job.bot     = r_s1_pix;
        o_job.col     = r_s1_col;
        o_job.row     = r_s1_row;
        o_job.blur_en = r_s1_blur;
        o_job.pass_en = r_s1_pass;
        o_job.done    = r_s1_done;
    end

endmodule

// ===== design/gb3_back.sv =====
// Back end: kernel sum, result ordering and output register.
module gb3_back
    import gb3_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_empty,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic r_out_v, r_pend_v;
    t_res r_out, r_pend;
    t_res blur_res, pass_res;
    logic out_free;

    assign out_free = !r_out_v || i_ready;
    assign o_pop    = !i_empty && out_free && !r_pend_v;

    always_comb begin
        blur_res      = '0;
        blur_res.col  = i_job.col - 1'b1;
        blur_res.row  = i_job.row - 1'b1;
        blur_res.pix  = blur_pix(i_job);
        blur_res.last = !i_job.pass_en;
        blur_res.done = 1'b0;
        pass_res      = '0;
        pass_res.col  = i_job.col;
        pass_res.row  = i_job.row;
        pass_res.pix  = i_job.bot;
        pass_res.last = 1'b1;
        pass_res.done = i_job.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else if (out_free) begin
            if (r_pend_v) begin
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
            end else if (o_pop) begin
                r_out_v  <= i_job.blur_en || i_job.pass_en;
                r_pend_v <= i_job.blur_en && i_job.pass_en;
            end else begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_v) begin
                r_out <= r_pend;
            end else if (o_pop) begin
                r_out  <= i_job.blur_en ? blur_res : pass_res;
                r_pend <= pass_res;
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

// ===== design/gb3_checker.sv =====
// Port-level checks for the RGB blur, bound to the top level.
module gb3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end not on the last result of a request");

    a_first_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            m_axis_tdata[10:0] != 11'd0 && m_axis_tdata[26:11] != 16'd0)
        else $error("leading result of a pair is not an interior pixel");

endmodule

bind rgb_gaussian_blur_3x3 gb3_checker u_gb3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
